/* sv/sspg_pkg.sv */
// Package for the stepper step pulse generator.
// Holds the fixed constants, the one-hot state codes and the percent/delay tables.
// No dependencies.
`default_nettype none

package sspg_pkg;

    localparam int PULSES_PER_TURN = 3200;
    localparam int LONGEST_DELAY   = 5000;
    localparam int SHORTEST_DELAY  = 80;
    localparam int DELAY_SPAN      = LONGEST_DELAY - SHORTEST_DELAY;
    localparam int DEFAULT_PERCENT = 70;
    localparam int FULL_PERCENT    = 100;

    localparam int DELAY_W = 13;
    localparam int PCT_W   = 7;
    localparam int COUNT_W = 28;
    localparam int TGT_W   = 16;
    localparam int GOAL_W  = 32;
    localparam int VAL_W   = 17;
    localparam int UNIT_W  = 37;
    localparam int TAB_N   = FULL_PERCENT + 1;

    localparam logic [DELAY_W-1:0] ELAPSED_MAX = '1;

    // command codes
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_SPEED  = 3'd1;
    localparam logic [2:0] CMD_FASTER = 3'd2;
    localparam logic [2:0] CMD_SLOWER = 3'd3;
    localparam logic [2:0] CMD_DIR    = 3'd4;
    localparam logic [2:0] CMD_RUN    = 3'd5;
    localparam logic [2:0] CMD_STOP   = 3'd6;
    localparam logic [2:0] CMD_TURN   = 3'd7;

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_EXEC      = 8'b0000_0010,
        ST_TICK_CMP  = 8'b0000_0100,
        ST_TICK_PEND = 8'b0000_1000,
        ST_TICK_CNT  = 8'b0001_0000,
        ST_TICK_CHK  = 8'b0010_0000,
        ST_GOAL      = 8'b0100_0000,
        ST_FIN       = 8'b1000_0000
    } state_t;

    function automatic int delay_of(input int p);
        int d;
        d = LONGEST_DELAY - (p * DELAY_SPAN) / FULL_PERCENT;
        if (d < 0) d = 0;
        if (d > int'(ELAPSED_MAX)) d = int'(ELAPSED_MAX);
        return d;
    endfunction

    function automatic logic [TAB_N*DELAY_W-1:0] make_delay_tab();
        logic [TAB_N*DELAY_W-1:0] t;
        t = '0;
        for (int p = 0; p < TAB_N; p++) begin
            t[p*DELAY_W +: DELAY_W] = DELAY_W'(delay_of(p));
        end
        return t;
    endfunction

    // readback of the percent that each table delay maps back to
    function automatic logic [TAB_N*PCT_W-1:0] make_pct_tab();
        logic [TAB_N*PCT_W-1:0] t;
        int r;
        t = '0;
        for (int p = 0; p < TAB_N; p++) begin
            if (DELAY_SPAN <= 0) begin
                r = 0;
            end
            else begin
                r = ((LONGEST_DELAY - delay_of(p)) * FULL_PERCENT) / DELAY_SPAN;
            end
            if (r < 0) r = 0;
            if (r > FULL_PERCENT) r = FULL_PERCENT;
            t[p*PCT_W +: PCT_W] = PCT_W'(r);
        end
        return t;
    endfunction

    localparam logic [TAB_N*DELAY_W-1:0] DELAY_TAB = make_delay_tab();
    localparam logic [TAB_N*PCT_W-1:0]   PCT_TAB   = make_pct_tab();

endpackage

`default_nettype wire

/* sv/stepper_step_pulse_generator_top.sv */
// Stepper step pulse generator, top level.
// Depends on sspg_pkg (constants, state codes, percent/delay tables).
//
//   channel  | signals                               | notes
//   ---------+---------------------------------------+--------------------------
//   input    | in_valid, in_stall, mode, value       | one command or tick word
//   output   | out_valid, out_stall, step_level,     | one status word per input
//            | direction_pin, enable_n,              |
//            | speed_percent, turning                |
//   config   | cfg_we, cfg_data                      | torque hold bit, write only
//
// Every word passes EXEC and FIN; a turn adds GOAL, a tick adds TICK_CMP and
// TICK_PEND, plus TICK_CNT and TICK_CHK on a move step; one 37-bit add/sub unit is reused.
// in_stall is high from accept until the status word is loaded into the
// output register; a stalled output holds the sequencer in its last step.
// Reset values: 70 percent speed (delay 1556), stopped, no move pending.
`default_nettype none

module stepper_step_pulse_generator_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic                               cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [2:0]                         mode,
    input  wire logic signed [sspg_pkg::VAL_W-1:0]  value,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    step_level,
    output logic                                    direction_pin,
    output logic                                    enable_n,
    output logic [sspg_pkg::PCT_W-1:0]              speed_percent,
    output logic                                    turning
);

    sspg_pkg::state_t state_reg, state_next;

    logic                                hold_reg;
    logic [2:0]                          mode_reg;
    logic signed [sspg_pkg::VAL_W-1:0]   val_reg;
    logic [sspg_pkg::DELAY_W-1:0]        hp_reg;
    logic [sspg_pkg::PCT_W-1:0]          pct_reg;
    logic                                run_reg;
    logic                                dir_reg;
    logic                                latch_reg;
    logic [sspg_pkg::DELAY_W-1:0]        elapsed_reg;
    logic                                step_reg;
    logic [sspg_pkg::COUNT_W-1:0]        count_reg;
    logic [sspg_pkg::TGT_W-1:0]          target_reg;
    logic [sspg_pkg::GOAL_W-1:0]         goal_reg;
    logic                                drive_reg;
    logic                                hit_reg;

    logic                                out_valid_reg;
    logic                                step_out_reg;
    logic                                dir_out_reg;
    logic                                en_out_reg;
    logic [sspg_pkg::PCT_W-1:0]          pct_out_reg;
    logic                                turn_out_reg;

    // shared add/sub unit
    logic signed [sspg_pkg::UNIT_W-1:0]  op_a;
    logic signed [sspg_pkg::UNIT_W-1:0]  op_b;
    logic                                op_sub;
    logic signed [sspg_pkg::UNIT_W-1:0]  unit_res;
    logic                                unit_neg;

    logic signed [sspg_pkg::UNIT_W-1:0]  done_ext;
    logic signed [sspg_pkg::UNIT_W-1:0]  goal_ext;
    logic [sspg_pkg::PCT_W-1:0]          pidx;
    logic                                accept;
    logic                                out_free;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != sspg_pkg::ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign done_ext = sspg_pkg::UNIT_W'({count_reg, 8'b0});
    assign goal_ext = sspg_pkg::UNIT_W'(goal_reg);

    always_comb
    begin
        op_a   = '0;
        op_b   = '0;
        op_sub = 1'b0;
        case (state_reg)
            sspg_pkg::ST_EXEC:
            begin
                case (mode_reg)
                    sspg_pkg::CMD_TICK:
                    begin
                        op_a = sspg_pkg::UNIT_W'(elapsed_reg);
                        op_b = sspg_pkg::UNIT_W'(1);
                    end
                    sspg_pkg::CMD_FASTER, sspg_pkg::CMD_SLOWER:
                    begin
                        op_a   = sspg_pkg::UNIT_W'(pct_reg);
                        op_b   = sspg_pkg::UNIT_W'(val_reg);
                        op_sub = (mode_reg == sspg_pkg::CMD_SLOWER);
                    end
                    default:
                    begin
                        op_a = sspg_pkg::UNIT_W'(val_reg);
                    end
                endcase
            end
            sspg_pkg::ST_TICK_CMP:
            begin
                op_a   = sspg_pkg::UNIT_W'(hp_reg);
                op_b   = sspg_pkg::UNIT_W'(elapsed_reg);
                op_sub = 1'b1;
            end
            sspg_pkg::ST_TICK_CNT:
            begin
                op_a = sspg_pkg::UNIT_W'(count_reg);
                op_b = sspg_pkg::UNIT_W'(1);
            end
            sspg_pkg::ST_TICK_PEND, sspg_pkg::ST_TICK_CHK, sspg_pkg::ST_FIN:
            begin
                op_a   = done_ext;
                op_b   = goal_ext;
                op_sub = 1'b1;
            end
            default:
            begin
                op_a = '0;
            end
        endcase
    end

    assign unit_res = op_sub ? (op_a - op_b) : (op_a + op_b);
    assign unit_neg = unit_res[sspg_pkg::UNIT_W-1];

    // clamp to 0..100 for the table index
    always_comb
    begin
        if (unit_neg) begin
            pidx = '0;
        end
        else if (unit_res > sspg_pkg::UNIT_W'(sspg_pkg::FULL_PERCENT)) begin
            pidx = sspg_pkg::PCT_W'(sspg_pkg::FULL_PERCENT);
        end
        else begin
            pidx = unit_res[sspg_pkg::PCT_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sspg_pkg::ST_IDLE:
            begin
                if (accept) state_next = sspg_pkg::ST_EXEC;
            end
            sspg_pkg::ST_EXEC:
            begin
                if (mode_reg == sspg_pkg::CMD_TICK) begin
                    state_next = sspg_pkg::ST_TICK_CMP;
                end
                else if (mode_reg == sspg_pkg::CMD_TURN) begin
                    state_next = sspg_pkg::ST_GOAL;
                end
                else begin
                    state_next = sspg_pkg::ST_FIN;
                end
            end
            sspg_pkg::ST_TICK_CMP:  state_next = sspg_pkg::ST_TICK_PEND;
            sspg_pkg::ST_TICK_PEND:
            begin
                state_next = (unit_neg && hit_reg) ? sspg_pkg::ST_TICK_CNT
                                                   : sspg_pkg::ST_FIN;
            end
            sspg_pkg::ST_TICK_CNT:  state_next = sspg_pkg::ST_TICK_CHK;
            sspg_pkg::ST_TICK_CHK:  state_next = sspg_pkg::ST_FIN;
            sspg_pkg::ST_GOAL:      state_next = sspg_pkg::ST_FIN;
            sspg_pkg::ST_FIN:
            begin
                if (out_free) state_next = sspg_pkg::ST_IDLE;
            end
            default:                state_next = sspg_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= sspg_pkg::ST_IDLE;
            hold_reg      <= 1'b0;
            hp_reg        <= sspg_pkg::DELAY_TAB[sspg_pkg::DEFAULT_PERCENT*sspg_pkg::DELAY_W
                                                 +: sspg_pkg::DELAY_W];
            pct_reg       <= sspg_pkg::PCT_TAB[sspg_pkg::DEFAULT_PERCENT*sspg_pkg::PCT_W
                                               +: sspg_pkg::PCT_W];
            run_reg       <= 1'b0;
            dir_reg       <= 1'b0;
            latch_reg     <= 1'b0;
            elapsed_reg   <= '0;
            step_reg      <= 1'b0;
            count_reg     <= '0;
            target_reg    <= '0;
            goal_reg      <= '0;
            drive_reg     <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            if (cfg_we) hold_reg <= cfg_data;
            if (state_reg == sspg_pkg::ST_FIN && out_free) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall) begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                sspg_pkg::ST_EXEC:
                begin
                    case (mode_reg)
                        sspg_pkg::CMD_TICK:
                        begin
                            if (elapsed_reg != sspg_pkg::ELAPSED_MAX) begin
                                elapsed_reg <= unit_res[sspg_pkg::DELAY_W-1:0];
                            end
                        end
                        sspg_pkg::CMD_SPEED, sspg_pkg::CMD_FASTER, sspg_pkg::CMD_SLOWER:
                        begin
                            hp_reg  <= sspg_pkg::DELAY_TAB[pidx*sspg_pkg::DELAY_W
                                                           +: sspg_pkg::DELAY_W];
                            pct_reg <= sspg_pkg::PCT_TAB[pidx*sspg_pkg::PCT_W
                                                         +: sspg_pkg::PCT_W];
                        end
                        sspg_pkg::CMD_DIR:  dir_reg <= (val_reg != '0);
                        sspg_pkg::CMD_RUN:
                        begin
                            run_reg   <= 1'b1;
                            drive_reg <= 1'b1;
                        end
                        sspg_pkg::CMD_STOP:
                        begin
                            run_reg   <= 1'b0;
                            drive_reg <= 1'b0;
                        end
                        default:
                        begin
                            target_reg <= val_reg[sspg_pkg::VAL_W-1] ? '0
                                          : val_reg[sspg_pkg::TGT_W-1:0];
                            drive_reg  <= 1'b1;
                        end
                    endcase
                end
                sspg_pkg::ST_TICK_CMP:
                begin
                    // free run wins; hit is cleared while running, so the move sees no step
                    hit_reg <= unit_neg && !run_reg;
                    if (unit_neg && run_reg) begin
                        elapsed_reg <= '0;
                        latch_reg   <= dir_reg;
                        step_reg    <= !step_reg;
                    end
                end
                sspg_pkg::ST_TICK_PEND:
                begin
                    if (unit_neg && hit_reg) begin
                        elapsed_reg <= '0;
                        latch_reg   <= dir_reg;
                        step_reg    <= !step_reg;
                    end
                end
                sspg_pkg::ST_TICK_CNT:
                begin
                    count_reg <= unit_res[sspg_pkg::COUNT_W-1:0];
                end
                sspg_pkg::ST_TICK_CHK:
                begin
                    if (!unit_neg) begin
                        count_reg  <= '0;
                        target_reg <= '0;
                        goal_reg   <= '0;
                        drive_reg  <= 1'b0;
                    end
                end
                sspg_pkg::ST_GOAL:
                begin
                    goal_reg <= sspg_pkg::GOAL_W'(target_reg)
                                * sspg_pkg::GOAL_W'(sspg_pkg::PULSES_PER_TURN);
                end
                default:
                begin
                    hit_reg <= hit_reg;
                end
            endcase
        end
    end

    // input capture and output word, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept) begin
            mode_reg <= mode;
            val_reg  <= value;
        end
        if (state_reg == sspg_pkg::ST_FIN && out_free) begin
            step_out_reg <= step_reg;
            dir_out_reg  <= latch_reg;
            en_out_reg   <= !(hold_reg || drive_reg);
            pct_out_reg  <= pct_reg;
            turn_out_reg <= unit_neg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign step_level    = step_out_reg;
    assign direction_pin = dir_out_reg;
    assign enable_n      = en_out_reg;
    assign speed_percent = pct_out_reg;
    assign turning       = turn_out_reg;

endmodule

`default_nettype wire
